[rtl/ps2_scancode_to_ascii_fifo_unit_macros.svh]
// Assertion macros for the scan code translator RTL.
`ifndef PS2_SCANCODE_TO_ASCII_FIFO_UNIT_MACROS_SVH
`define PS2_SCANCODE_TO_ASCII_FIFO_UNIT_MACROS_SVH

// Checked on every clock edge once reset has been released.
`define PS2SA_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Checked on every clock edge, reset included.
`define PS2SA_ASSERT_ALWAYS(name, prop, msg) \
  name: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

[rtl/ps2sa_pkg.sv]
// Shared types, constants and the set 1 lookup table of the scan code translator.
`default_nettype none

package ps2sa_pkg;

  localparam logic       OP_SCAN      = 1'b0;
  localparam logic       OP_READ      = 1'b1;
  localparam logic [7:0] RELEASE_MASK = 8'h80;
  localparam logic [7:0] CODE_LIMIT   = 8'd58;
  localparam logic [6:0] ESC_CHAR     = 7'h1B;

  // One classified transaction handed from the front end to the back end.
  typedef struct packed {
    logic       is_read;
    logic       mapped;
    logic [6:0] ch;
  } cmd_t;

  // One result as it leaves the block.
  typedef struct packed {
    logic       char_valid;
    logic [6:0] char_code;
    logic       translated;
    logic       dropped;
    logic [5:0] pending;
  } res_t;

  // Lowercase US layout; unmapped codes give zero.
  function automatic logic [6:0] set1_char(input logic [5:0] code);
    logic [6:0] ch;
    unique case (code)
      6'd1:    ch = ESC_CHAR;
      6'd2:    ch = 7'h31;
      6'd3:    ch = 7'h32;
      6'd4:    ch = 7'h33;
      6'd5:    ch = 7'h34;
      6'd6:    ch = 7'h35;
      6'd7:    ch = 7'h36;
      6'd8:    ch = 7'h37;
      6'd9:    ch = 7'h38;
      6'd10:   ch = 7'h39;
      6'd11:   ch = 7'h30;
      6'd12:   ch = 7'h2D;
      6'd13:   ch = 7'h3D;
      6'd14:   ch = 7'h08;
      6'd15:   ch = 7'h09;
      6'd16:   ch = 7'h71;
      6'd17:   ch = 7'h77;
      6'd18:   ch = 7'h65;
      6'd19:   ch = 7'h72;
      6'd20:   ch = 7'h74;
      6'd21:   ch = 7'h79;
      6'd22:   ch = 7'h75;
      6'd23:   ch = 7'h69;
      6'd24:   ch = 7'h6F;
      6'd25:   ch = 7'h70;
      6'd26:   ch = 7'h5B;
      6'd27:   ch = 7'h5D;
      6'd28:   ch = 7'h0A;
      6'd30:   ch = 7'h61;
      6'd31:   ch = 7'h73;
      6'd32:   ch = 7'h64;
      6'd33:   ch = 7'h66;
      6'd34:   ch = 7'h67;
      6'd35:   ch = 7'h68;
      6'd36:   ch = 7'h6A;
      6'd37:   ch = 7'h6B;
      6'd38:   ch = 7'h6C;
      6'd39:   ch = 7'h3B;
      6'd40:   ch = 7'h27;
      6'd41:   ch = 7'h60;
      6'd43:   ch = 7'h5C;
      6'd44:   ch = 7'h7A;
      6'd45:   ch = 7'h78;
      6'd46:   ch = 7'h63;
      6'd47:   ch = 7'h76;
      6'd48:   ch = 7'h62;
      6'd49:   ch = 7'h6E;
      6'd50:   ch = 7'h6D;
      6'd51:   ch = 7'h2C;
      6'd52:   ch = 7'h2E;
      6'd53:   ch = 7'h2F;
      6'd55:   ch = 7'h2A;
      6'd57:   ch = 7'h20;
      default: ch = 7'h00;
    endcase
    return ch;
  endfunction

endpackage

`default_nettype wire

[rtl/ps2sa_queue.sv]
// Two-entry register queue used between the pipeline parts and at the result side.
`default_nettype none

module ps2sa_queue #(
  parameter int unsigned WIDTH = 8
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire logic [WIDTH-1:0] data_i,
  output logic                  full_o,
  input  wire logic             pop_i,
  output logic      [WIDTH-1:0] data_o,
  output logic                  empty_o
);

  logic [WIDTH-1:0] slot_q [2];
  logic             wr_ptr_q, rd_ptr_q;
  logic [1:0]       count_q;
  logic             do_push, do_pop;

  assign full_o  = (count_q == 2'd2);
  assign empty_o = (count_q == 2'd0);
  assign do_push = push_i & ~full_o;
  assign do_pop  = pop_i & ~empty_o;
  assign data_o  = slot_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (do_pop) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + 2'd1;
      end else if (do_pop && !do_push) begin
        count_q <= count_q - 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

`default_nettype wire

[rtl/ps2sa_front.sv]
// Front end: classifies each accepted transaction and translates scan codes.
`default_nettype none

module ps2sa_front (
  input  wire logic          accept_i,
  input  wire logic          op_i,
  input  wire logic [7:0]    scan_code_i,
  input  wire logic          enable_i,
  output logic               cmd_push_o,
  output ps2sa_pkg::cmd_t    cmd_o
);

  import ps2sa_pkg::*;

  logic       in_range;
  logic [6:0] ch;

  // Release codes have bit 7 set and are therefore also beyond the table.
  assign in_range = ((scan_code_i & RELEASE_MASK) == 8'h00) && (scan_code_i < CODE_LIMIT);
  assign ch       = set1_char(scan_code_i[5:0]);

  assign cmd_push_o    = accept_i;
  assign cmd_o.is_read = (op_i == OP_READ);
  assign cmd_o.mapped  = (op_i == OP_SCAN) & enable_i & in_range & (ch != 7'h00);
  assign cmd_o.ch      = ch;

endmodule

`default_nettype wire

[rtl/ps2sa_back.sv]
// Back end: character ring buffer, pointer update and result assembly.
`default_nettype none

module ps2sa_back #(
  parameter int unsigned BUF_DEPTH = 64
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            cmd_valid_i,
  input  wire ps2sa_pkg::cmd_t cmd_i,
  output logic                 cmd_pop_o,
  output logic                 res_push_o,
  output ps2sa_pkg::res_t      res_o,
  input  wire logic            res_full_i
);

  import ps2sa_pkg::*;

  localparam int unsigned PTR_W = $clog2(BUF_DEPTH);

  logic [6:0]       store_q [BUF_DEPTH];
  logic [6:0]       rdata_q;
  logic [PTR_W-1:0] wptr_q, rptr_q, wptr_d, rptr_d, wnext, rnext;
  logic [PTR_W:0]   count;
  logic [PTR_W+6:0] count_ext;
  logic             b_valid_q;
  res_t             b_res_q, b_res_d;
  logic             a_go, b_push, is_full, do_write, do_read, is_scan_hit;

  assign b_push = b_valid_q & ~res_full_i;
  assign a_go   = cmd_valid_i & (~b_valid_q | b_push);

  assign wnext = (wptr_q == PTR_W'(BUF_DEPTH - 1)) ? '0 : wptr_q + 1'b1;
  assign rnext = (rptr_q == PTR_W'(BUF_DEPTH - 1)) ? '0 : rptr_q + 1'b1;

  assign is_scan_hit = ~cmd_i.is_read & cmd_i.mapped;
  assign is_full     = (wnext == rptr_q);
  assign do_write    = a_go & is_scan_hit & ~is_full;
  assign do_read     = a_go & cmd_i.is_read & (wptr_q != rptr_q);

  assign wptr_d = do_write ? wnext : wptr_q;
  assign rptr_d = do_read ? rnext : rptr_q;

  assign count = {1'b0, wptr_d} - {1'b0, rptr_d}
               + ((wptr_d < rptr_d) ? (PTR_W + 1)'(BUF_DEPTH) : '0);
  assign count_ext = (PTR_W + 7)'(count);

  always_comb begin
    b_res_d            = '0;
    b_res_d.char_valid = do_read;
    b_res_d.translated = is_scan_hit;
    b_res_d.dropped    = is_scan_hit & is_full;
    b_res_d.pending    = count_ext[5:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q    <= '0;
      rptr_q    <= '0;
      b_valid_q <= 1'b0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      if (a_go) begin
        b_valid_q <= 1'b1;
      end else if (b_push) begin
        b_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_write) begin
      store_q[wptr_q] <= cmd_i.ch;
    end
    if (do_read) begin
      rdata_q <= store_q[rptr_q];
    end
    if (a_go) begin
      b_res_q <= b_res_d;
    end
  end

  assign cmd_pop_o  = a_go;
  assign res_push_o = b_push;

  always_comb begin
    res_o           = b_res_q;
    res_o.char_code = b_res_q.char_valid ? rdata_q : 7'h00;
  end

endmodule

`default_nettype wire

[rtl/ps2_scancode_to_ascii_fifo_unit.sv]
// Top level of the PS/2 set 1 scan code to ASCII translator with character buffer.
//
//   Channel   Handshake            Payload
//   input     push / full          op_i, scan_code_i
//   result    empty / pop          char_valid_o, char_code_o, translated_o,
//                                  dropped_o, pending_o
//   config    cfg_valid_i / ready  cfg_data_i (enable)
//
// The block sustains one transaction per cycle on each side when nothing downstream
// stalls; the character store has one write and one registered read port, and the
// back end uses one of them per transaction.
// An accepted transaction passes the command queue, the back end result register and
// the result queue before it shows on the result ports.
// Reset is asynchronous and active low; it clears the pointers, the queues and
// the enable register. The character store itself is not cleared.
// A stalled result side fills the result queue, then the back end, then the
// command queue, after which full rises; the front end never loses an item.
`default_nettype none

`include "ps2_scancode_to_ascii_fifo_unit_macros.svh"

module ps2_scancode_to_ascii_fifo_unit #(
  parameter int unsigned BUF_DEPTH = 64
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       push,
  output logic            full,
  input  wire logic       op_i,
  input  wire logic [7:0] scan_code_i,
  output logic            empty,
  input  wire logic       pop,
  output logic            char_valid_o,
  output logic [6:0]      char_code_o,
  output logic            translated_o,
  output logic            dropped_o,
  output logic [5:0]      pending_o,
  input  wire logic       cfg_valid_i,
  output logic            cfg_ready_o,
  input  wire logic       cfg_data_i
);

  import ps2sa_pkg::*;

  logic enable_q;
  logic accept;
  logic cmd_push, cmd_pop, cmd_empty;
  cmd_t cmd_in, cmd_out;
  logic res_push, res_full;
  res_t res_in, res_out;

  // The enable register can be written in any cycle; writes should land while idle, which the block does not enforce.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enable_q <= 1'b0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      enable_q <= cfg_data_i;
    end
  end

  assign accept = push & ~full;

  // Front end: classification and table lookup in the accepting cycle.
  ps2sa_front u_front (
    .accept_i    (accept),
    .op_i        (op_i),
    .scan_code_i (scan_code_i),
    .enable_i    (enable_q),
    .cmd_push_o  (cmd_push),
    .cmd_o       (cmd_in)
  );

  // Short command queue, which lets the front end and back end stall apart.
  ps2sa_queue #(
    .WIDTH ($bits(cmd_t))
  ) u_cmd_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (cmd_push),
    .data_i  (cmd_in),
    .full_o  (full),
    .pop_i   (cmd_pop),
    .data_o  (cmd_out),
    .empty_o (cmd_empty)
  );

  // Back end: ring buffer, pointers and the pending count.
  ps2sa_back #(
    .BUF_DEPTH (BUF_DEPTH)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (~cmd_empty),
    .cmd_i       (cmd_out),
    .cmd_pop_o   (cmd_pop),
    .res_push_o  (res_push),
    .res_o       (res_in),
    .res_full_i  (res_full)
  );

  // Result queue; its head is what the result ports show.
  ps2sa_queue #(
    .WIDTH ($bits(res_t))
  ) u_res_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .data_i  (res_in),
    .full_o  (res_full),
    .pop_i   (pop),
    .data_o  (res_out),
    .empty_o (empty)
  );

  assign char_valid_o = res_out.char_valid;
  assign char_code_o  = res_out.char_code;
  assign translated_o = res_out.translated;
  assign dropped_o    = res_out.dropped;
  assign pending_o    = res_out.pending;

  // A character can only be dropped if it was translated in the first place.
  `PS2SA_ASSERT(a_drop_needs_translate, !empty && dropped_o |-> translated_o, "drop without translation")
  // A result is either a read or a scan code transaction, never both.
  `PS2SA_ASSERT(a_read_or_scan, !empty && char_valid_o |-> !translated_o, "read result marked translated")
  // Without a popped character the code field must be zero.
  `PS2SA_ASSERT(a_code_zero, !empty && !char_valid_o |-> char_code_o == 7'h00, "stale character code")
  // A clock edge seen with reset held leaves no result on offer in the next cycle.
  `PS2SA_ASSERT_ALWAYS(a_empty_in_reset, !rst_ni |=> empty, "result offered during reset")

endmodule

`default_nettype wire

[tb/tb_ps2_scancode_to_ascii_fifo_unit.sv]
// Self-checking testbench for the PS/2 set 1 scan code to ASCII translator and its buffer.
`timescale 1ns / 100ps

module tb_ps2_scancode_to_ascii_fifo_unit;

  import ps2sa_pkg::*;

  // Generous ceiling on the run: well over what the slowest correct run takes.
  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned MAX_REPORTS = 10;

  // One keyboard-side transaction waiting to be offered to the block.
  typedef struct packed {
    logic       op;
    logic [7:0] code;
  } keystroke_t;

  logic       clk_i       = 1'b0;
  logic       rst_ni      = 1'b0;
  logic       push        = 1'b0;
  logic       full;
  logic       op_i        = 1'b0;
  logic [7:0] scan_code_i = 8'h00;
  logic       empty;
  logic       pop         = 1'b0;
  logic       char_valid_o;
  logic [6:0] char_code_o;
  logic       translated_o;
  logic       dropped_o;
  logic [5:0] pending_o;
  logic       cfg_valid_i = 1'b0;
  logic       cfg_ready_o;
  logic       cfg_data_i  = 1'b0;

  ps2_scancode_to_ascii_fifo_unit dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push        (push),
    .full        (full),
    .op_i        (op_i),
    .scan_code_i (scan_code_i),
    .empty       (empty),
    .pop         (pop),
    .char_valid_o(char_valid_o),
    .char_code_o (char_code_o),
    .translated_o(translated_o),
    .dropped_o   (dropped_o),
    .pending_o   (pending_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i)
  );

  // Free-running clock with a 10 ns period.
  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Transactions still to be offered, and the results the block owes us, oldest first.
  keystroke_t keystroke_q[$];
  res_t       awaited_results[$];

  // Our own copy of the translator state. The pointers are six bits wide, so they wrap
  // at 64 slots exactly as the default buffer depth does.
  logic [6:0] shadow_chars [64];
  logic [5:0] shadow_wr_ptr = '0;
  logic [5:0] shadow_rd_ptr = '0;
  logic       shadow_enable = 1'b0;

  // Idling controls, changed only between phases while the block is quiet.
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;

  bit          item_taken  = 1'b0;
  keystroke_t  next_item;
  res_t        got_result;
  res_t        want_result;
  int unsigned cycle_count = 0;
  int unsigned n_bad       = 0;
  int unsigned n_in        = 0;
  int unsigned n_out       = 0;
  int unsigned n_chars     = 0;
  int unsigned n_trans     = 0;
  int unsigned n_drops     = 0;

  // Lowercase US layout of scan code set 1; a zero marks a key with no character.
  function automatic logic [6:0] us_key_char(input logic [5:0] code);
    case (code)
      6'd1:    return ESC_CHAR;
      6'd2:    return 7'h31;
      6'd3:    return 7'h32;
      6'd4:    return 7'h33;
      6'd5:    return 7'h34;
      6'd6:    return 7'h35;
      6'd7:    return 7'h36;
      6'd8:    return 7'h37;
      6'd9:    return 7'h38;
      6'd10:   return 7'h39;
      6'd11:   return 7'h30;
      6'd12:   return 7'h2D;
      6'd13:   return 7'h3D;
      6'd14:   return 7'h08;
      6'd15:   return 7'h09;
      6'd16:   return 7'h71;
      6'd17:   return 7'h77;
      6'd18:   return 7'h65;
      6'd19:   return 7'h72;
      6'd20:   return 7'h74;
      6'd21:   return 7'h79;
      6'd22:   return 7'h75;
      6'd23:   return 7'h69;
      6'd24:   return 7'h6F;
      6'd25:   return 7'h70;
      6'd26:   return 7'h5B;
      6'd27:   return 7'h5D;
      6'd28:   return 7'h0A;
      6'd30:   return 7'h61;
      6'd31:   return 7'h73;
      6'd32:   return 7'h64;
      6'd33:   return 7'h66;
      6'd34:   return 7'h67;
      6'd35:   return 7'h68;
      6'd36:   return 7'h6A;
      6'd37:   return 7'h6B;
      6'd38:   return 7'h6C;
      6'd39:   return 7'h3B;
      6'd40:   return 7'h27;
      6'd41:   return 7'h60;
      6'd43:   return 7'h5C;
      6'd44:   return 7'h7A;
      6'd45:   return 7'h78;
      6'd46:   return 7'h63;
      6'd47:   return 7'h76;
      6'd48:   return 7'h62;
      6'd49:   return 7'h6E;
      6'd50:   return 7'h6D;
      6'd51:   return 7'h2C;
      6'd52:   return 7'h2E;
      6'd53:   return 7'h2F;
      6'd55:   return 7'h2A;
      6'd57:   return 7'h20;
      default: return 7'h00;
    endcase
  endfunction

  // A make code (release bit clear) below the table limit that carries a character.
  function automatic bit is_mapped_make(input logic [7:0] code);
    return ((code & RELEASE_MASK) == 8'h00) && (code < CODE_LIMIT)
           && (us_key_char(code[5:0]) != 7'h00);
  endfunction

  // Works out the result of one accepted transaction and advances the shadow state.
  function automatic res_t predict_keystroke(input logic op, input logic [7:0] code);
    res_t       r;
    logic [5:0] nxt;
    r = '0;
    if (op == OP_SCAN) begin
      // Scan codes are only looked at while enabled; release codes, codes past the
      // table and keys without a character leave everything as it was.
      if (shadow_enable && is_mapped_make(code)) begin
        r.translated = 1'b1;
        nxt = shadow_wr_ptr + 6'd1;
        if (nxt != shadow_rd_ptr) begin
          shadow_chars[shadow_wr_ptr] = us_key_char(code[5:0]);
          shadow_wr_ptr = nxt;
        end else begin
          // One slot always stays free, so a full buffer loses the character.
          r.dropped = 1'b1;
        end
      end
    end else if (shadow_wr_ptr != shadow_rd_ptr) begin
      // Reads ignore the scan code field and work whether or not the block is enabled.
      r.char_valid  = 1'b1;
      r.char_code   = shadow_chars[shadow_rd_ptr];
      shadow_rd_ptr = shadow_rd_ptr + 6'd1;
    end
    r.pending = shadow_wr_ptr - shadow_rd_ptr;
    return r;
  endfunction

  function automatic logic [7:0] random_mapped_code();
    logic [7:0] c;
    do begin
      c = 8'($urandom_range(1, 57));
    end while (!is_mapped_make(c));
    return c;
  endfunction

  // Queues one burst of transactions and returns how many of them the block acts on.
  // Most bursts look like real use: typing with the matching release codes, or a run
  // of reads. The odd flood drives the buffer into overflow, and noise bursts carry
  // arbitrary bytes on either operation.
  function automatic int queue_burst();
    int unsigned kind;
    int unsigned n;
    int          counted;
    logic [7:0]  c;
    logic        op;
    counted = 0;
    kind = $urandom_range(0, 99);
    if (kind < 40) begin
      n = $urandom_range(1, 12);
      repeat (n) begin
        c = random_mapped_code();
        keystroke_q.push_back('{OP_SCAN, c});
        if (shadow_enable) counted++;
        if ($urandom_range(0, 1) == 1) keystroke_q.push_back('{OP_SCAN, c | RELEASE_MASK});
      end
    end else if (kind < 70) begin
      n = $urandom_range(1, 12);
      repeat (n) begin
        keystroke_q.push_back('{OP_READ, 8'($urandom_range(0, 255))});
        counted++;
      end
    end else if (kind < 75) begin
      n = $urandom_range(60, 70);
      repeat (n) begin
        keystroke_q.push_back('{OP_SCAN, random_mapped_code()});
        if (shadow_enable) counted++;
      end
    end else begin
      n = $urandom_range(1, 8);
      repeat (n) begin
        op = 1'($urandom_range(0, 1));
        c  = 8'($urandom_range(0, 255));
        keystroke_q.push_back('{op, c});
        if (op == OP_READ || (shadow_enable && is_mapped_make(c))) counted++;
      end
    end
    return counted;
  endfunction

  task automatic fill_phase(input int target);
    int counted;
    counted = 0;
    while (counted < target) counted += queue_burst();
  endtask

  // Blocks until every queued transaction has gone in and every result has come out,
  // then lets the pipeline settle.
  task automatic wait_drained();
    while (keystroke_q.size() != 0 || push || awaited_results.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  // Writes the enable register through its own valid/ready channel.
  task automatic write_enable(input logic value);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    shadow_enable = value;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // Driver: all inputs change on the falling edge. A transaction stays on the ports
  // until the block takes it, and a new one is only chosen once the previous one has
  // gone in or the line was idle. Both sides idle at the rates of the current phase.
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (!push || item_taken) begin
        if (keystroke_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          next_item = keystroke_q.pop_front();
          push        <= 1'b1;
          op_i        <= next_item.op;
          scan_code_i <= next_item.code;
        end else begin
          push <= 1'b0;
        end
      end
      pop <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  // Monitor: handshakes are judged on the rising edge, from values that settled
  // before it. An accepted input transaction gets its prediction at once, and an
  // accepted result is checked field by field against the oldest prediction.
  always @(posedge clk_i) begin
    item_taken = rst_ni && push && !full;
    if (item_taken) begin
      awaited_results.push_back(predict_keystroke(op_i, scan_code_i));
      n_in++;
    end
    if (rst_ni && pop && !empty) begin
      got_result = '{char_valid_o, char_code_o, translated_o, dropped_o, pending_o};
      n_out++;
      if (awaited_results.size() == 0) begin
        n_bad++;
        if (n_bad <= MAX_REPORTS)
          $display("Unexpected result at cycle %0d: valid=%0b char=%h trans=%0b drop=%0b pend=%0d",
                   cycle_count, got_result.char_valid, got_result.char_code,
                   got_result.translated, got_result.dropped, got_result.pending);
      end else begin
        want_result = awaited_results.pop_front();
        if (want_result.char_valid) n_chars++;
        if (want_result.translated) n_trans++;
        if (want_result.dropped) n_drops++;
        if (got_result.char_valid !== want_result.char_valid
            || got_result.char_code !== want_result.char_code
            || got_result.translated !== want_result.translated
            || got_result.dropped !== want_result.dropped
            || got_result.pending !== want_result.pending) begin
          n_bad++;
          if (n_bad <= MAX_REPORTS) begin
            $display("Mismatch on result %0d at cycle %0d:", n_out, cycle_count);
            $display("  expected valid=%0b char=%h trans=%0b drop=%0b pend=%0d",
                     want_result.char_valid, want_result.char_code,
                     want_result.translated, want_result.dropped, want_result.pending);
            $display("  actual   valid=%0b char=%h trans=%0b drop=%0b pend=%0d",
                     got_result.char_valid, got_result.char_code,
                     got_result.translated, got_result.dropped, got_result.pending);
          end
        end
      end
    end
  end

  // Watchdog: a hung handshake ends the run as a failure.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d results outstanding",
               cycle_count, awaited_results.size());
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin
    // Reset is held from the start and released on a falling edge, once only.
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    send_idle_pct = 25;
    recv_idle_pct = 70;

    // With the block disabled a scan code is ignored, and a read of the empty buffer
    // returns nothing.
    write_enable(1'b0);
    keystroke_q.push_back('{OP_SCAN, 8'h10});
    keystroke_q.push_back('{OP_READ, 8'h00});
    wait_drained();

    // Directed cases once enabled: the first and last mapped codes, unmapped codes
    // inside the table, the table limit, release codes, reads carrying a scan code
    // that must be ignored, and a read that finds the buffer empty again.
    write_enable(1'b1);
    keystroke_q.push_back('{OP_SCAN, 8'h01});
    keystroke_q.push_back('{OP_SCAN, 8'h02});
    keystroke_q.push_back('{OP_SCAN, 8'h39});
    keystroke_q.push_back('{OP_SCAN, 8'h00});
    keystroke_q.push_back('{OP_SCAN, 8'h1D});
    keystroke_q.push_back('{OP_SCAN, 8'h3A});
    keystroke_q.push_back('{OP_SCAN, 8'h7F});
    keystroke_q.push_back('{OP_SCAN, 8'h80});
    keystroke_q.push_back('{OP_SCAN, 8'h81});
    keystroke_q.push_back('{OP_SCAN, 8'hFF});
    keystroke_q.push_back('{OP_SCAN, 8'hB9});
    keystroke_q.push_back('{OP_SCAN, 8'h37});
    keystroke_q.push_back('{OP_SCAN, 8'h2B});
    keystroke_q.push_back('{OP_READ, 8'hFF});
    keystroke_q.push_back('{OP_READ, 8'h01});
    keystroke_q.push_back('{OP_READ, 8'h00});
    keystroke_q.push_back('{OP_READ, 8'h55});
    keystroke_q.push_back('{OP_READ, 8'hAA});
    keystroke_q.push_back('{OP_READ, 8'h39});
    wait_drained();

    // Random phases: slow receiver first, then slow sender, then full speed, with
    // short disabled stretches in between so that ignored scan codes meet a
    // partly filled buffer.
    fill_phase(240);
    wait_drained();
    write_enable(1'b0);
    fill_phase(30);
    wait_drained();

    send_idle_pct = 70;
    recv_idle_pct = 25;
    write_enable(1'b1);
    fill_phase(240);
    wait_drained();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_enable(1'b0);
    fill_phase(20);
    wait_drained();
    write_enable(1'b1);
    fill_phase(240);
    wait_drained();

    if (awaited_results.size() != 0) begin
      n_bad++;
      $display("%0d results never arrived", awaited_results.size());
    end

    $display("Run covered %0d transactions in and %0d results out over %0d cycles.",
             n_in, n_out, cycle_count);
    $display("Characters read back: %0d, keys translated: %0d, lost to a full buffer: %0d.",
             n_chars, n_trans, n_drops);
    if (n_bad == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("%0d mismatches in total", n_bad);
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
